/* rtl/ulrd_pkg.sv */
// ----------------------------------------------------------------------------
// ulrd_pkg: shared types and constants of the uart line receive demux
// Item kinds, classified item, result record and character codes.
// ----------------------------------------------------------------------------
package ulrd_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_RX     = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_POP    = 2'd3
  } kind_e;

  // character codes
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_F  = 8'h46;

  // saturation point of the pending line count
  localparam logic [7:0] LINE_COUNT_MAX = 8'hFF;

  // one request after classification in the front part
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        is_nl;
    logic        is_n;
    logic        is_g;
    logic        is_hex;
    logic [3:0]  digit;
  } item_t;

  // one result record
  typedef struct packed {
    logic        response_done;
    logic        response_ng;
    logic [15:0] response_value;
    logic        response_waiting;
    logic        pop_valid;
    logic [7:0]  pop_byte;
    logic        pop_last;
    logic [7:0]  lines_pending;
  } res_t;

endpackage

/* rtl/uart_line_receive_demux.sv */
// ----------------------------------------------------------------------------
// uart_line_receive_demux: receive-side demux for a line-delimited uart link
// Splits received bytes between response capture and a message ring.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  request   in         push / full        kind_i, rx_byte_i
//  result    out        pop / empty        response_*_o, pop_*_o, lines_pending_o
//  config    in         cfg_we_i           cfg_wdata_i (message enable)
//
//  one request per cycle unless a ring read or a full result queue stalls it;
//  a pop that finds a pending line reads the ring through its registered read
//  port and holds off the next request. a result passes the request queue and
//  result queue registers, and for a ring pop also the ring read register.
//  reset clears all control state; ring contents are not cleared.
//  a full result queue stalls the back part, which then fills the request queue.
// ----------------------------------------------------------------------------
module uart_line_receive_demux #(
  parameter int RING_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic        response_done_o,
  output logic        response_ng_o,
  output logic [15:0] response_value_o,
  output logic        response_waiting_o,
  output logic        pop_valid_o,
  output logic [7:0]  pop_byte_o,
  output logic        pop_last_o,
  output logic [7:0]  lines_pending_o
);
  import ulrd_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_take;
  res_t  res_in;
  res_t  res_out;
  logic  res_push;
  logic  res_room;

  // request intake
  ulrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // execution
  ulrd_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_room_i   (res_room),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // result queue
  ulrd_res_q u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_room_o (res_room),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res_out)
  );

  assign response_done_o    = res_out.response_done;
  assign response_ng_o      = res_out.response_ng;
  assign response_value_o   = res_out.response_value;
  assign response_waiting_o = res_out.response_waiting;
  assign pop_valid_o        = res_out.pop_valid;
  assign pop_byte_o         = res_out.pop_byte;
  assign pop_last_o         = res_out.pop_last;
  assign lines_pending_o    = res_out.lines_pending;

endmodule

/* rtl/ulrd_front.sv */
// ----------------------------------------------------------------------------
// ulrd_front: request intake and classification
// Decodes each request and holds it in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module ulrd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    rx_byte_i,
  output logic          full_o,
  output logic          item_valid_o,
  output ulrd_pkg::item_t item_o,
  input  logic          item_take_i
);
  import ulrd_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       cls;
  logic        do_push, do_take;

  // classify the incoming request
  always_comb begin
    cls.kind   = kind_e'(kind_i);
    cls.data   = rx_byte_i;
    cls.is_nl  = (rx_byte_i == CHAR_NL);
    cls.is_n   = (rx_byte_i == CHAR_N);
    cls.is_g   = (rx_byte_i == CHAR_G);
    cls.is_hex = 1'b0;
    cls.digit  = 4'd0;
    if (rx_byte_i >= CHAR_0 && rx_byte_i <= CHAR_9) begin
      cls.is_hex = 1'b1;
      cls.digit  = rx_byte_i[3:0];
    end else if (rx_byte_i >= CHAR_A && rx_byte_i <= CHAR_F) begin
      cls.is_hex = 1'b1;
      cls.digit  = rx_byte_i[3:0] + 4'd9;
    end
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_take      = item_take_i && item_valid_o;

  // queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_take;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

/* rtl/ulrd_back.sv */
// ----------------------------------------------------------------------------
// ulrd_back: request execution
// Runs response capture, the message ring and the pending line count.
// ----------------------------------------------------------------------------
module ulrd_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            item_valid_i,
  input  ulrd_pkg::item_t item_i,
  output logic            item_take_o,
  input  logic            res_room_i,
  output logic            res_push_o,
  output ulrd_pkg::res_t  res_o
);
  import ulrd_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  logic [7:0]    ring [RING_DEPTH];
  logic [7:0]    rd_data_q;

  logic          msg_en_q;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [7:0]    cnt_q, cnt_d;
  logic          armed_q, armed_d;
  logic [1:0]    idx_q, idx_d;
  logic          first_n_q, first_n_d;
  logic          ng_q, ng_d;
  logic          hex_open_q, hex_open_d;
  logic [15:0]   acc_q, acc_d;
  logic          pop_busy_q, pop_busy_d;

  logic          take;
  logic          mem_we, mem_re;
  logic          done;
  logic          pop_last;

  assign take        = item_valid_i && !pop_busy_q && res_room_i;
  assign item_take_o = take;
  assign pop_last    = (rd_data_q == CHAR_NL);

  // execute one request, or finish a ring read
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    armed_d    = armed_q;
    idx_d      = idx_q;
    first_n_d  = first_n_q;
    ng_d       = ng_q;
    hex_open_d = hex_open_q;
    acc_d      = acc_q;
    pop_busy_d = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    done       = 1'b0;
    res_push_o = 1'b0;

    if (pop_busy_q) begin
      rd_ptr_d   = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      if (pop_last) begin
        cnt_d = cnt_q - 8'd1;
      end
      res_push_o = 1'b1;
    end else if (take) begin
      res_push_o = 1'b1;
      unique case (item_i.kind)
        KIND_RX: begin
          if (armed_q) begin
            if (idx_q == 2'd0) begin
              first_n_d = item_i.is_n;
            end else if (idx_q == 2'd1) begin
              ng_d = first_n_q && item_i.is_g;
            end
            if (idx_q != 2'd2) begin
              idx_d = idx_q + 2'd1;
            end
            if (hex_open_q) begin
              if (item_i.is_hex) begin
                acc_d = {acc_q[11:0], item_i.digit};
              end else begin
                hex_open_d = 1'b0;
              end
            end
            if (item_i.is_nl) begin
              armed_d = 1'b0;
              done    = 1'b1;
            end
          end else if (msg_en_q) begin
            mem_we   = 1'b1;
            wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
            if (item_i.is_nl && cnt_q != LINE_COUNT_MAX) begin
              cnt_d = cnt_q + 8'd1;
            end
          end
        end
        KIND_ARM: begin
          armed_d    = 1'b1;
          idx_d      = 2'd0;
          first_n_d  = 1'b0;
          ng_d       = 1'b0;
          hex_open_d = 1'b1;
          acc_d      = 16'd0;
        end
        KIND_CANCEL: begin
          armed_d = 1'b0;
        end
        KIND_POP: begin
          if (cnt_q != 8'd0) begin
            mem_re     = 1'b1;
            pop_busy_d = 1'b1;
            res_push_o = 1'b0;
          end
        end
        default: begin
          armed_d = armed_q;
        end
      endcase
    end
  end

  // result record
  always_comb begin
    res_o.response_done    = done;
    res_o.response_ng      = ng_d;
    res_o.response_value   = acc_d;
    res_o.response_waiting = armed_d;
    res_o.pop_valid        = pop_busy_q;
    res_o.pop_byte         = pop_busy_q ? rd_data_q : 8'd0;
    res_o.pop_last         = pop_busy_q && pop_last;
    res_o.lines_pending    = cnt_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_en_q   <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= 8'd0;
      armed_q    <= 1'b0;
      idx_q      <= 2'd0;
      first_n_q  <= 1'b0;
      ng_q       <= 1'b0;
      hex_open_q <= 1'b1;
      acc_q      <= 16'd0;
      pop_busy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        msg_en_q <= cfg_wdata_i;
      end
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      armed_q    <= armed_d;
      idx_q      <= idx_d;
      first_n_q  <= first_n_d;
      ng_q       <= ng_d;
      hex_open_q <= hex_open_d;
      acc_q      <= acc_d;
      pop_busy_q <= pop_busy_d;
    end
  end

  // message ring memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[wr_ptr_q] <= item_i.data;
    end
    if (mem_re) begin
      rd_data_q <= ring[rd_ptr_q];
    end
  end

endmodule

/* rtl/ulrd_res_q.sv */
// ----------------------------------------------------------------------------
// ulrd_res_q: result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module ulrd_res_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_push_i,
  input  ulrd_pkg::res_t res_i,
  output logic           res_room_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ulrd_pkg::res_t res_o
);
  import ulrd_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign res_room_o = (cnt_q != 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign res_o      = slot_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ res_push_i;
      rd_ptr_q <= rd_ptr_q ^ do_pop;
      cnt_q    <= cnt_q + {1'b0, res_push_i} - {1'b0, do_pop};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
